// ===== design/prime_sieve_engine_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the prime sieve engine
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef PRIME_SIEVE_ENGINE_CORE_ASSERT_SVH
`define PRIME_SIEVE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sieve engine assertion failed");

// Next-cycle implication.
`define PSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sieve engine assertion failed");

`endif

// ===== design/pse_pkg.sv =====
// ---------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the prime sieve engine.
// ---------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned CUR_W = VAL_W + 1;

  localparam logic [CUR_W-1:0] CURSOR_START = 17'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [VAL_W-1:0] limit;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] prime;
    logic             found;
  } rsp_t;

  // Top level to multiple marker
  typedef struct packed {
    logic             go;
    logic [VAL_W-1:0] prime;
    logic [VAL_W-1:0] limit;
  } mark_cmd_t;

  // Multiple marker to top level
  typedef struct packed {
    logic             done;
    logic             wr_en;
    logic [CUR_W-1:0] wr_addr;
  } mark_stat_t;

endpackage

// ===== design/pse_stream_if.sv =====
// ---------------------------------------------------------------------------
// pse_stream_if
// Valid/ready channel carrying one request or one result.
// ---------------------------------------------------------------------------
interface pse_stream_if #(
  parameter type data_t = logic
);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

// ===== design/pse_marker.sv =====
// ---------------------------------------------------------------------------
// pse_marker
// Squares a new prime and walks its multiples from the square up to the
// limit, one bitmap write per cycle.
// ---------------------------------------------------------------------------
module pse_marker (
  input  logic                   clk,
  input  logic                   rst,
  input  pse_pkg::mark_cmd_t     cmd,
  output pse_pkg::mark_stat_t    stat
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_SQUARE,
    M_CHECK,
    M_RUN
  } mstate_t;

  mstate_t                       state;
  logic [pse_pkg::VAL_W-1:0]     step;
  logic [pse_pkg::VAL_W-1:0]     limit;
  logic [2*pse_pkg::VAL_W-1:0]   square;
  logic [pse_pkg::CUR_W-1:0]     addr;
  logic [pse_pkg::CUR_W-1:0]     addr_next;
  logic [pse_pkg::CUR_W-1:0]     limit_ext;
  logic                          square_over;

  assign limit_ext   = {1'b0, limit};
  assign addr_next   = addr + {1'b0, step};
  assign square_over = square > {{pse_pkg::VAL_W{1'b0}}, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (cmd.go) begin
            step  <= cmd.prime;
            limit <= cmd.limit;
            state <= M_SQUARE;
          end
        end
        M_SQUARE: begin
          square <= step * step;
          state  <= M_CHECK;
        end
        M_CHECK: begin
          // square fits the address width whenever it is within the limit
          addr  <= square[pse_pkg::CUR_W-1:0];
          state <= square_over ? M_IDLE : M_RUN;
        end
        M_RUN: begin
          addr <= addr_next;
          if (addr_next > limit_ext) begin
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_comb begin
    stat.wr_en   = (state == M_RUN);
    stat.wr_addr = addr;
    stat.done    = ((state == M_CHECK) && square_over) ||
                   ((state == M_RUN) && (addr_next > limit_ext));
  end

endmodule

// ===== design/prime_sieve_engine_core.sv =====
// Prime sieve engine. A start request (operation 0) stores the limit, saturated
// to MAP_DEPTH-1, and sweeps the composite bitmap clear from 0 up to that limit,
// one entry per cycle; its result is prime 0, found 0. A fetch request
// (operation 1) scans the bitmap from the cursor, one entry per cycle through
// the single read port of the bitmap memory, then for a prime whose square is
// within the limit writes one bitmap entry per multiple from the square upward,
// and returns the prime with found 1, or found 0 once the cursor has passed the
// limit. Any request waits in S_EMIT while the output register still holds a
// result the sink has not taken. One request is worked at a time; a new request
// is accepted while the previous result still waits in the output register. No
// clearing pass runs after reset: the bitmap is only read up to a limit set by a
// start, which clears that range first.
module prime_sieve_engine_core #(
  parameter int unsigned MAP_DEPTH = 65536
) (
  input  logic         clk,
  input  logic         rst,
  pse_stream_if.sink   req,
  pse_stream_if.source rsp
);

  `include "prime_sieve_engine_core_assert.svh"

  localparam int unsigned ADDR_W    = $clog2(MAP_DEPTH);
  localparam int unsigned MAX_LIM_I = MAP_DEPTH - 1;
  localparam logic [pse_pkg::VAL_W-1:0] MAX_LIMIT = MAX_LIM_I[pse_pkg::VAL_W-1:0];

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_MARK,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [pse_pkg::VAL_W-1:0]    held_limit;
  logic [pse_pkg::CUR_W-1:0]    cursor;
  logic [pse_pkg::CUR_W-1:0]    limit_ext;
  logic                         rd_pend;
  logic [pse_pkg::VAL_W-1:0]    rd_addr;
  logic [pse_pkg::VAL_W-1:0]    clr_addr;
  pse_pkg::rsp_t                res;
  pse_pkg::rsp_t                out_data;
  logic                         out_valid;
  logic [pse_pkg::VAL_W-1:0]    lim_sat;

  logic                         map_mem [MAP_DEPTH];
  logic                         map_q;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic                         mem_wd;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_ra;

  logic                         prime_hit;
  logic                         past_end;

  pse_pkg::mark_cmd_t           mark_cmd;
  pse_pkg::mark_stat_t          mark_stat;

  pse_marker u_marker (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mark_cmd),
    .stat (mark_stat)
  );

  assign lim_sat   = (req.data.limit > MAX_LIMIT) ? MAX_LIMIT : req.data.limit;
  assign limit_ext = {1'b0, held_limit};

  // Last read returned an unmarked entry: that entry is the next prime
  assign prime_hit = rd_pend && !map_q;
  assign past_end  = cursor > limit_ext;

  assign mark_cmd.go    = (state == S_SCAN) && prime_hit;
  assign mark_cmd.prime = rd_addr;
  assign mark_cmd.limit = held_limit;

  assign mem_we = (state == S_CLEAR) || mark_stat.wr_en;
  assign mem_wa = (state == S_CLEAR) ? clr_addr[ADDR_W-1:0]
                                     : mark_stat.wr_addr[ADDR_W-1:0];
  assign mem_wd = (state != S_CLEAR);
  assign mem_re = (state == S_SCAN) && !prime_hit && !past_end;
  assign mem_ra = cursor[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      map_q <= map_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_limit <= '0;
      cursor     <= pse_pkg::CURSOR_START;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.data.operation == pse_pkg::OP_START) begin
              held_limit <= lim_sat;
              cursor     <= pse_pkg::CURSOR_START;
              clr_addr   <= '0;
              state      <= S_CLEAR;
            end else begin
              rd_pend <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == held_limit) begin
            res   <= '0;
            state <= S_EMIT;
          end
        end
        S_SCAN: begin
          priority if (prime_hit) begin
            rd_pend <= 1'b0;
            state   <= S_MARK;
          end else if (past_end) begin
            rd_pend <= 1'b0;
            res     <= '0;
            state   <= S_EMIT;
          end else begin
            // issue a read one entry ahead of the check
            rd_pend <= 1'b1;
            rd_addr <= cursor[pse_pkg::VAL_W-1:0];
            cursor  <= cursor + 1'b1;
          end
        end
        S_MARK: begin
          if (mark_stat.done) begin
            res.prime <= rd_addr;
            res.found <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `PSE_ASSERT_IMP(a_read_within_limit, mem_re, cursor <= limit_ext)
  `PSE_ASSERT_IMP(a_mark_within_limit, mark_stat.wr_en, mark_stat.wr_addr <= limit_ext)
  `PSE_ASSERT_IMP(a_mark_from_square, mark_stat.wr_en, mark_stat.wr_addr >= 17'd4)
  `PSE_ASSERT_NEXT(a_hit_enters_mark, mark_cmd.go, state == S_MARK)
  `PSE_ASSERT_IMP(a_found_prime_nonzero, rsp.valid && rsp.data.found, rsp.data.prime >= 16'd2)

endmodule
